[src/twbe_pkg.sv]
// Shared types and constants for the three-band waveform envelope.
// No dependencies; every other source file imports this package.
`default_nettype none
package twbe_pkg;
  localparam int MAX_WINDOW = 4096;
  localparam int LOW_RADIUS = 3;
  localparam int MID_RADIUS = 10;
  localparam int MAX_PIXELS = 4096;
  localparam int LAG = (LOW_RADIUS > MID_RADIUS) ? LOW_RADIUS : MID_RADIUS;
  localparam int LOW_DEPTH = LAG + LOW_RADIUS + 1;
  localparam int MID_DEPTH = LAG + MID_RADIUS + 1;
  localparam int HIGH_DEPTH = LAG + 1;
  localparam int LOW_IW = $clog2(LOW_DEPTH);
  localparam int MID_IW = $clog2(MID_DEPTH);
  localparam int HIGH_IW = $clog2(HIGH_DEPTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_W = 28;
  localparam int DEN_W = 13;

  localparam logic [2:0] REG_PIXEL_COUNT = 3'd0;
  localparam logic [2:0] REG_LOW_GAIN = 3'd1;
  localparam logic [2:0] REG_MID_GAIN = 3'd2;
  localparam logic [2:0] REG_HIGH_GAIN = 3'd3;
  localparam logic [2:0] REG_PEAK_MIX = 3'd4;
  localparam logic [2:0] REG_HEIGHT_SCALE = 3'd5;

  typedef struct packed {
    logic [19:0] low_sum;
    logic [19:0] mid_sum;
    logic [7:0]  low_peak;
    logic [7:0]  mid_peak;
    logic [7:0]  high_peak;
    logic [12:0] count;
  } pix_rec_t;

  typedef struct packed {
    logic [12:0] pixel_count;
    logic [9:0]  low_gain;
    logic [9:0]  mid_gain;
    logic [9:0]  high_gain;
    logic [8:0]  peak_mix;
    logic [15:0] height_scale;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;
endpackage
`default_nettype wire

[src/twbe_front.sv]
// Front end: accepts samples and accumulates peaks, sums and count per pixel.
// Depends on twbe_pkg; hands finished pixel records to twbe_queue.
`default_nettype none
module twbe_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [31:0]         s_tdata,
  input  wire logic                s_tuser,
  input  wire logic                s_tlast,
  input  wire twbe_pkg::q_stat_t   q_stat,
  output logic                     push,
  output twbe_pkg::pix_rec_t       rec
);
  import twbe_pkg::*;

  pix_rec_t acc;
  pix_rec_t acc_next;
  logic     accept;
  logic     take;
  logic [7:0] lo, mi, hi;

  assign lo = s_tdata[7:0];
  assign mi = s_tdata[15:8];
  assign hi = s_tdata[23:16];
  assign s_tready = !q_stat.full;
  assign accept = s_tvalid && s_tready;
  assign take = accept && !s_tuser && (acc.count < 13'(MAX_WINDOW));
  assign push = accept && s_tlast;
  assign rec = acc_next;

  always_comb begin
    acc_next = acc;
    if (take) begin
      if (lo > acc.low_peak) acc_next.low_peak = lo;
      if (mi > acc.mid_peak) acc_next.mid_peak = mi;
      if (hi > acc.high_peak) acc_next.high_peak = hi;
      acc_next.low_sum = acc.low_sum + 20'(lo);
      acc_next.mid_sum = acc.mid_sum + 20'(mi);
      acc_next.count = acc.count + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      acc <= '0;
    end else if (accept) begin
      acc <= acc_next;
    end
  end
endmodule
`default_nettype wire

[src/twbe_queue.sv]
// Short request queue of pixel records between the front and back ends.
// Depends on twbe_pkg.
`default_nettype none
module twbe_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire twbe_pkg::pix_rec_t wr_rec,
  input  wire logic               pop,
  output twbe_pkg::pix_rec_t      rd_rec,
  output twbe_pkg::q_stat_t       q_stat
);
  import twbe_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  pix_rec_t entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign q_stat.full = (count == (PW+1)'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty)) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count step");
endmodule
`default_nettype wire

[src/twbe_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Depends on twbe_pkg.
`default_nettype none
module twbe_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [twbe_pkg::DIV_W-1:0]    num,
  input  wire logic [twbe_pkg::DEN_W-1:0]    den,
  output logic                               done,
  output logic [twbe_pkg::DIV_W-1:0]         quo
);
  import twbe_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dv;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(DIV_W);
        quo <= num;
        rem <= '0;
        dv <= den;
      end else if (busy) begin
        rem <= fits ? DEN_W'(trial - {1'b0, dv}) : trial[DEN_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[src/twbe_back.sv]
// Back end: band heights per pixel, history rings, smoothing and extents.
// Depends on twbe_pkg and twbe_div; reads records from twbe_queue.
`default_nettype none
module twbe_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire twbe_pkg::cfg_t     cfg,
  input  wire twbe_pkg::q_stat_t  q_stat,
  input  wire twbe_pkg::pix_rec_t rec_in,
  output logic                    pop,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [63:0]             m_tdata,
  output logic                    m_tlast
);
  import twbe_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADIV_LO, ST_AWAIT_LO, ST_ADIV_MI, ST_AWAIT_MI, ST_MIX, ST_BODY,
    ST_GAIN, ST_WRITE, ST_PLAN, ST_SETUP, ST_RD_L, ST_AC_L, ST_RD_M, ST_AC_M,
    ST_SDIV_L, ST_SWAIT_L, ST_SDIV_M, ST_SWAIT_M, ST_EXT, ST_OUT, ST_DONE
  } state_t;

  state_t state;
  pix_rec_t rec;
  logic [15:0] avg_l, avg_m, body_l, body_m;
  logic [24:0] mix_l, mix_m;
  logic [17:0] h_l, h_m, h_h, sm_l, sm_m, hh;
  logic [11:0] p, o;
  logic flush;
  logic [LOW_IW-1:0] wp_l, idx_l;
  logic [MID_IW-1:0] wp_m, idx_m;
  logic [HIGH_IW-1:0] wp_h, idx_h;
  logic [4:0] n_l, n_m, cnt;
  logic [22:0] acc_l, acc_m;
  logic [33:0] ext_l, ext_m, ext_h;
  logic [17:0] mem_l [LOW_DEPTH];
  logic [17:0] mem_m [MID_DEPTH];
  logic [17:0] mem_h [HIGH_DEPTH];
  logic [17:0] rd_l, rd_m, rd_h;

  logic div_start, div_done;
  logic [DIV_W-1:0] div_num, div_q;
  logic [DEN_W-1:0] div_den;

  logic [8:0] mix_eff;
  logic [15:0] pk_l, pk_m;
  logic [12:0] pc_eff;
  logic last_line;
  logic [11:0] lo_l, lo_m, hi_l, hi_m, d_l, d_m, d_h;
  logic [12:0] hs_l, hs_m;
  logic [6:0] t_l, t_m, t_h;

  twbe_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  assign pop = (state == ST_IDLE) && !q_stat.empty;

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    unique case (state)
      ST_ADIV_LO: begin
        div_start = 1'b1;
        div_num = {rec.low_sum, 8'd0};
        div_den = rec.count;
      end
      ST_ADIV_MI: begin
        div_start = 1'b1;
        div_num = {rec.mid_sum, 8'd0};
        div_den = rec.count;
      end
      ST_SDIV_L: begin
        div_start = 1'b1;
        div_num = DIV_W'(acc_l);
        div_den = DEN_W'(n_l);
      end
      ST_SDIV_M: begin
        div_start = 1'b1;
        div_num = DIV_W'(acc_m);
        div_den = DEN_W'(n_m);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mix_eff = (cfg.peak_mix > 9'd256) ? 9'd256 : cfg.peak_mix;
    pk_l = ({rec.low_peak, 8'd0} < avg_l) ? avg_l : {rec.low_peak, 8'd0};
    pk_m = ({rec.mid_peak, 8'd0} < avg_m) ? avg_m : {rec.mid_peak, 8'd0};
    if (cfg.pixel_count == '0) pc_eff = 13'd1;
    else if (cfg.pixel_count > 13'(MAX_PIXELS)) pc_eff = 13'(MAX_PIXELS);
    else pc_eff = cfg.pixel_count;
    last_line = ({1'b0, p} + 13'd1) >= pc_eff;
    lo_l = (o >= 12'(LOW_RADIUS)) ? o - 12'(LOW_RADIUS) : '0;
    lo_m = (o >= 12'(MID_RADIUS)) ? o - 12'(MID_RADIUS) : '0;
    hs_l = {1'b0, o} + 13'(LOW_RADIUS);
    hs_m = {1'b0, o} + 13'(MID_RADIUS);
    hi_l = (hs_l > {1'b0, p}) ? p : hs_l[11:0];
    hi_m = (hs_m > {1'b0, p}) ? p : hs_m[11:0];
    d_l = p - lo_l;
    d_m = p - lo_m;
    d_h = p - o;
    t_l = (7'(wp_l) >= 7'(d_l)) ? 7'(wp_l) - 7'(d_l) : 7'(wp_l) + 7'(LOW_DEPTH) - 7'(d_l);
    t_m = (7'(wp_m) >= 7'(d_m)) ? 7'(wp_m) - 7'(d_m) : 7'(wp_m) + 7'(MID_DEPTH) - 7'(d_m);
    t_h = (7'(wp_h) >= 7'(d_h)) ? 7'(wp_h) - 7'(d_h)
                                : 7'(wp_h) + 7'(HIGH_DEPTH) - 7'(d_h);
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      mem_l[wp_l] <= h_l;
      mem_m[wp_m] <= h_m;
      mem_h[wp_h] <= h_h;
    end
    rd_l <= mem_l[idx_l];
    rd_m <= mem_m[idx_m];
    rd_h <= mem_h[idx_h];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      p <= '0;
      wp_l <= '0;
      wp_m <= '0;
      wp_h <= '0;
      m_tvalid <= 1'b0;
      flush <= 1'b0;
    end else begin
      if (m_tready && (state != ST_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            rec <= rec_in;
            if (rec_in.count == '0) begin
              h_l <= '0;
              h_m <= '0;
              h_h <= '0;
              state <= ST_WRITE;
            end else begin
              state <= ST_ADIV_LO;
            end
          end
        end
        ST_ADIV_LO: state <= ST_AWAIT_LO;
        ST_AWAIT_LO: begin
          if (div_done) begin
            avg_l <= div_q[15:0];
            state <= ST_ADIV_MI;
          end
        end
        ST_ADIV_MI: state <= ST_AWAIT_MI;
        ST_AWAIT_MI: begin
          if (div_done) begin
            avg_m <= div_q[15:0];
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          mix_l <= 25'(mix_eff) * 25'(pk_l - avg_l);
          mix_m <= 25'(mix_eff) * 25'(pk_m - avg_m);
          state <= ST_BODY;
        end
        ST_BODY: begin
          body_l <= 16'(avg_l + mix_l[24:8]);
          body_m <= 16'(avg_m + mix_m[24:8]);
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          h_l <= 18'((26'(body_l) * 26'(cfg.low_gain)) >> 8);
          h_m <= 18'((26'(body_m) * 26'(cfg.mid_gain)) >> 8);
          h_h <= 18'(rec.high_peak) * 18'(cfg.high_gain);
          state <= ST_WRITE;
        end
        ST_WRITE: state <= ST_PLAN;
        ST_PLAN: begin
          if (last_line) begin
            flush <= 1'b1;
            o <= (p >= 12'(LAG)) ? p - 12'(LAG) : '0;
            state <= ST_SETUP;
          end else if (p >= 12'(LAG)) begin
            flush <= 1'b0;
            o <= p - 12'(LAG);
            state <= ST_SETUP;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SETUP: begin
          idx_l <= LOW_IW'(t_l);
          idx_m <= MID_IW'(t_m);
          idx_h <= HIGH_IW'(t_h);
          n_l <= 5'(hi_l - lo_l + 12'd1);
          n_m <= 5'(hi_m - lo_m + 12'd1);
          cnt <= 5'(hi_l - lo_l + 12'd1);
          acc_l <= '0;
          acc_m <= '0;
          state <= ST_RD_L;
        end
        ST_RD_L: state <= ST_AC_L;
        ST_AC_L: begin
          acc_l <= acc_l + 23'(rd_l);
          idx_l <= (idx_l == LOW_IW'(LOW_DEPTH - 1)) ? '0 : idx_l + 1'b1;
          if (cnt == 5'd1) begin
            cnt <= n_m;
            state <= ST_RD_M;
          end else begin
            cnt <= cnt - 1'b1;
            state <= ST_RD_L;
          end
        end
        ST_RD_M: state <= ST_AC_M;
        ST_AC_M: begin
          acc_m <= acc_m + 23'(rd_m);
          idx_m <= (idx_m == MID_IW'(MID_DEPTH - 1)) ? '0 : idx_m + 1'b1;
          cnt <= cnt - 1'b1;
          state <= (cnt == 5'd1) ? ST_SDIV_L : ST_RD_M;
        end
        ST_SDIV_L: begin
          hh <= rd_h;
          state <= ST_SWAIT_L;
        end
        ST_SWAIT_L: begin
          if (div_done) begin
            sm_l <= div_q[17:0];
            state <= ST_SDIV_M;
          end
        end
        ST_SDIV_M: state <= ST_SWAIT_M;
        ST_SWAIT_M: begin
          if (div_done) begin
            sm_m <= div_q[17:0];
            state <= ST_EXT;
          end
        end
        ST_EXT: begin
          ext_l <= 34'(sm_l) * 34'(cfg.height_scale);
          ext_m <= 34'(sm_m) * 34'(cfg.height_scale);
          ext_h <= 34'(hh) * 34'(cfg.height_scale);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {4'd0,
                        (ext_h[33:28] != '0) ? 16'hFFFF : ext_h[27:12],
                        (ext_m[33:28] != '0) ? 16'hFFFF : ext_m[27:12],
                        (ext_l[33:28] != '0) ? 16'hFFFF : ext_l[27:12],
                        o};
            m_tlast <= flush && (o == p);
            if (flush && (o != p)) begin
              o <= o + 12'd1;
              state <= ST_SETUP;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (last_line) begin
            p <= '0;
            wp_l <= '0;
            wp_m <= '0;
            wp_h <= '0;
          end else begin
            p <= p + 12'd1;
            wp_l <= (wp_l == LOW_IW'(LOW_DEPTH - 1)) ? '0 : wp_l + 1'b1;
            wp_m <= (wp_m == MID_IW'(MID_DEPTH - 1)) ? '0 : wp_m + 1'b1;
            wp_h <= (wp_h == HIGH_IW'(HIGH_DEPTH - 1)) ? '0 : wp_h + 1'b1;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != ST_IDLE) else $error("pop did not start work");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result lost");
  a_ring_sync: assert property (@(posedge clk) disable iff (rst)
    (p == '0) |-> (wp_l == '0 && wp_m == '0 && wp_h == '0))
    else $error("ring pointer out of step");
endmodule
`default_nettype wire

[src/three_band_waveform_envelope.sv]
// Top level: register port and wiring of front end, queue and back end.
// Depends on twbe_pkg, twbe_front, twbe_queue, twbe_back.
//
// Channel  Dir  Payload
// s_*      in   tdata: low, mid, high levels; tuser: no_sample; tlast: ends_pixel
// m_*      out  tdata: pixel_index, low, mid, high extents; tlast: line_done
// APB      in   six configuration registers at byte addresses 0 to 20
//
// The front end takes one sample every cycle while the queue has room.
// The back end pops a record only when idle; time per pixel and result
// is set by the serial divider and one-port reads of the history rings.
// Reset is synchronous; a stalled output holds the back end, and a full
// queue holds the input.
`default_nettype none
module three_band_waveform_envelope (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // low_level, mid_level, high_level, zero pad
  input  wire logic        s_tuser,   // no_sample
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // pixel_index, low, mid, high extent, zero pad
  output logic             m_tlast
);
  import twbe_pkg::*;

  cfg_t     cfg;
  q_stat_t  q_stat;
  pix_rec_t wr_rec, rd_rec;
  logic     push, pop;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_count <= 13'd1024;
      cfg.low_gain <= 10'd64;
      cfg.mid_gain <= 10'd256;
      cfg.high_gain <= 10'd154;
      cfg.peak_mix <= 9'd90;
      cfg.height_scale <= 16'd256;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_PIXEL_COUNT: cfg.pixel_count <= pwdata[12:0];
        REG_LOW_GAIN: cfg.low_gain <= pwdata[9:0];
        REG_MID_GAIN: cfg.mid_gain <= pwdata[9:0];
        REG_HIGH_GAIN: cfg.high_gain <= pwdata[9:0];
        REG_PEAK_MIX: cfg.peak_mix <= pwdata[8:0];
        REG_HEIGHT_SCALE: cfg.height_scale <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      unique case (paddr[4:2])
        REG_PIXEL_COUNT: prdata = 32'(cfg.pixel_count);
        REG_LOW_GAIN: prdata = 32'(cfg.low_gain);
        REG_MID_GAIN: prdata = 32'(cfg.mid_gain);
        REG_HIGH_GAIN: prdata = 32'(cfg.high_gain);
        REG_PEAK_MIX: prdata = 32'(cfg.peak_mix);
        REG_HEIGHT_SCALE: prdata = 32'(cfg.height_scale);
        default: prdata = '0;
      endcase
    end
  end

  twbe_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .q_stat(q_stat), .push(push), .rec(wr_rec)
  );

  twbe_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_rec(wr_rec), .pop(pop),
    .rd_rec(rd_rec), .q_stat(q_stat)
  );

  twbe_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_stat(q_stat), .rec_in(rd_rec), .pop(pop),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );
endmodule
`default_nettype wire
